/* hdl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
// Each macro expands to one labeled concurrent assertion with an error report.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/nlrc_pkg.sv */
// Package of the node-list range counter: widths, character codes, status codes
// and the classified byte record passed from the front end to the back end.
`timescale 1ns / 1ps

package nlrc_pkg;

    // Default sizes of the running count and of a decoded range value.
    localparam int COUNT_BITS_DEF       = 32;
    localparam int RANGE_VALUE_BITS_DEF = 20;

    // Fixed field widths of the channels and of the configuration port.
    localparam int BYTE_BITS      = 8;
    localparam int OUT_TOTAL_BITS = 32;
    localparam int STATUS_BITS    = 3;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 8;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SEPARATOR  = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RANGE_MODE = 1'd1;

    // Configuration reset values.
    localparam logic [BYTE_BITS-1:0] SEPARATOR_RESET  = 8'h2C;
    localparam logic                 RANGE_MODE_RESET = 1'b1;

    // Characters with a fixed meaning.
    localparam logic [BYTE_BITS-1:0] CH_TERM  = 8'h00;
    localparam logic [BYTE_BITS-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_BITS-1:0] CH_OPEN  = 8'h5B;
    localparam logic [BYTE_BITS-1:0] CH_DASH  = 8'h2D;
    localparam logic [BYTE_BITS-1:0] CH_CLOSE = 8'h5D;
    localparam logic [BYTE_BITS-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_BITS-1:0] CH_NINE  = 8'h39;

    // Result status codes.
    localparam logic [STATUS_BITS-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_ZERO     = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_NEGATIVE = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_UNTERM   = 3'd4;

    // Depth of the queue between front end and back end.
    localparam int QUEUE_DEPTH = 2;

    // One byte after classification, with the mode it was taken under.
    typedef struct packed {
        logic       term;
        logic       delim;
        logic       open;
        logic       dash;
        logic       close;
        logic       digit;
        logic [3:0] digit_val;
        logic       rmode;
    } op_t;

endpackage

/* hdl/nlrc_if.sv */
// Stream interfaces of the node-list range counter: byte input and result output.
// Depends on nlrc_pkg for the field widths.
`timescale 1ns / 1ps

interface nlrc_in_if
    import nlrc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [BYTE_BITS-1:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface nlrc_out_if
    import nlrc_pkg::*;
();
    logic                             valid;
    logic                             ready;
    logic signed [OUT_TOTAL_BITS-1:0] entry_total;
    logic        [STATUS_BITS-1:0]    status_code;

    modport source (output valid, output entry_total, output status_code, input ready);
    modport sink   (input valid, input entry_total, input status_code, output ready);
endinterface

/* hdl/node_list_range_counter.sv */
// Node-list range counter: counts the entries of a zero-terminated node-list string.
// Top level; depends on nlrc_pkg, the stream interfaces, front end, queue and back end.
//
// Usage:
//   in_ch carries one character per transfer in text_byte; a zero byte ends the string.
//   out_ch carries one result per string: entry_total (saturating signed count) and
//   status_code (ok, zero, negative, empty string, unterminated range).
//   cfg_we/cfg_index/cfg_data write separator_char (index 0) and range_mode
//   (index 1); write them only while no string is in flight.
// Throughput: one character per cycle while the queue has room; the scan update
//   in the back end is one multiply-by-ten add and one saturating add.
// Path: an accepted terminator passes through the queue, behind any bytes queued
//   ahead of it, and its result is registered in the output register for out_ch.
// Stall: a result waits in the output register until taken; characters keep
//   being accepted into the two-entry queue and the back end keeps scanning
//   them, halting only at the next terminator, so in_ch.ready drops once the
//   queue fills behind a waiting result.
// Reset: clears the scan state, the queue and the output slot; the separator
//   returns to ',' and range mode to on. No clearing pass is needed.
`timescale 1ns / 1ps

module node_list_range_counter
    import nlrc_pkg::*;
#(
    parameter int COUNT_BITS       = COUNT_BITS_DEF,
    parameter int RANGE_VALUE_BITS = RANGE_VALUE_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    nlrc_in_if.sink                   in_ch,
    nlrc_out_if.source                out_ch
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_not_empty;
    op_t  q_in;
    op_t  q_head;

    // Classification and configuration.
    nlrc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    // Decoupling queue.
    nlrc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // Scan state and result register.
    nlrc_back #(
        .COUNT_BITS       (COUNT_BITS),
        .RANGE_VALUE_BITS (RANGE_VALUE_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_not_empty),
        .q_data  (q_head),
        .q_pop   (q_pop),
        .out_ch  (out_ch)
    );

endmodule

/* hdl/nlrc_front.sv */
// Front end: holds the configuration registers and classifies each input byte.
// Depends on nlrc_pkg and the input stream interface.
`timescale 1ns / 1ps

module nlrc_front
    import nlrc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    nlrc_in_if.sink                   in_ch,
    input  logic                      q_full,
    output logic                      q_push,
    output op_t                       q_data
);

    logic [BYTE_BITS-1:0] separator_reg;
    logic                 range_mode_reg;
    logic [BYTE_BITS-1:0] delim_char;
    logic [BYTE_BITS-1:0] b;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            separator_reg  <= SEPARATOR_RESET;
            range_mode_reg <= RANGE_MODE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SEPARATOR:  separator_reg  <= cfg_data;
                CFG_RANGE_MODE: range_mode_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // A transfer is taken whenever the queue has room.
    assign in_ch.ready = !q_full;
    assign q_push      = in_ch.valid && !q_full;

    // Classify the byte under the mode in force when it arrives.
    assign b          = in_ch.text_byte;
    assign delim_char = range_mode_reg ? CH_COMMA : separator_reg;

    always_comb
    begin
        q_data.term      = (b == CH_TERM);
        q_data.delim     = (b == delim_char);
        q_data.open      = range_mode_reg && (b == CH_OPEN);
        q_data.dash      = (b == CH_DASH);
        q_data.close     = (b == CH_CLOSE);
        q_data.digit     = (b >= CH_ZERO) && (b <= CH_NINE);
        q_data.digit_val = b[3:0];
        q_data.rmode     = range_mode_reg;
    end

endmodule

/* hdl/nlrc_queue.sv */
// Two-entry queue of classified bytes between the front end and the back end.
// Depends on nlrc_pkg for the record type and the depth.
`timescale 1ns / 1ps

module nlrc_queue
    import nlrc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_data,
    input  logic pop,
    output logic full,
    output logic not_empty,
    output op_t  head
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    op_t                 mem_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                do_pop;

    assign full      = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    // Entry storage; payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push && do_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* hdl/nlrc_back.sv */
// Back end: runs the scan state over classified bytes and registers the result.
// Depends on nlrc_pkg and the output stream interface.
`timescale 1ns / 1ps

module nlrc_back
    import nlrc_pkg::*;
#(
    parameter int COUNT_BITS       = COUNT_BITS_DEF,
    parameter int RANGE_VALUE_BITS = RANGE_VALUE_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  op_t        q_data,
    output logic       q_pop,
    nlrc_out_if.source out_ch
);

    localparam int RV = RANGE_VALUE_BITS;
    localparam int CB = COUNT_BITS;
    localparam int SW = ((CB > RV + 1) ? CB : RV + 1) + 1;
    localparam int EW = (CB > OUT_TOTAL_BITS) ? CB : OUT_TOTAL_BITS;

    localparam logic        [RV-1:0] ACC_LIM = {RV{1'b1}};
    localparam logic signed [SW-1:0] CMAX    = SW'((65'(1) << (CB - 1)) - 65'(1));
    localparam logic signed [SW-1:0] CMIN    = -CMAX - SW'(1);
    localparam logic signed [SW-1:0] ONE     = SW'(1);

    typedef enum logic [1:0] {PH_NORMAL, PH_FIRST, PH_LAST} phase_t;

    phase_t                  phase_reg, phase_next;
    logic                    after_sep_reg, after_sep_next;
    logic                    at_start_reg, at_start_next;
    logic signed [CB-1:0]    running_reg, running_next;
    logic        [RV-1:0]    start_reg, start_next;
    logic        [RV-1:0]    acc_reg, acc_next;
    logic                    stopped_reg, stopped_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [OUT_TOTAL_BITS-1:0] total_reg, total_next;
    logic        [STATUS_BITS-1:0]    status_reg, status_next;

    logic                    out_free;
    logic        [RV+4:0]    dig_sum;
    logic        [RV-1:0]    acc_digit;
    logic                    stop_digit;
    logic signed [RV:0]      delta;
    logic signed [CB-1:0]    final_total;
    logic signed [EW-1:0]    final_ext;

    // Signed add clamped to the bounds of the running count.
    function automatic logic signed [CB-1:0] sat_add(input logic signed [SW-1:0] a,
                                                     input logic signed [SW-1:0] d);
        logic signed [SW-1:0] s;
        s = a + d;
        if (s > CMAX)
        begin
            s = CMAX;
        end
        else if (s < CMIN)
        begin
            s = CMIN;
        end
        return s[CB-1:0];
    endfunction

    // A terminator waits only for a free output slot.
    assign out_free = !out_valid_reg || out_ch.ready;
    assign q_pop    = q_valid && (!q_data.term || out_free);

    // Next decimal digit folded into the accumulator, saturating.
    always_comb
    begin
        dig_sum    = (RV + 5)'((RV + 4)'(acc_reg) * 4'd10) + (RV + 5)'(q_data.digit_val);
        acc_digit  = acc_reg;
        stop_digit = stopped_reg;
        if (!stopped_reg)
        begin
            if (!q_data.digit)
            begin
                stop_digit = 1'b1;
            end
            else if (dig_sum > (RV + 5)'(ACC_LIM))
            begin
                acc_digit = ACC_LIM;
            end
            else
            begin
                acc_digit = dig_sum[RV-1:0];
            end
        end
    end

    // Range contribution and the closing count.
    assign delta       = $signed({1'b0, acc_reg}) - $signed({1'b0, start_reg});
    assign final_total = sat_add(SW'(running_reg), ONE);
    assign final_ext   = EW'(final_total);

    // Scan state update for one classified byte.
    always_comb
    begin
        phase_next     = phase_reg;
        after_sep_next = after_sep_reg;
        at_start_next  = at_start_reg;
        running_next   = running_reg;
        start_next     = start_reg;
        acc_next       = acc_reg;
        stopped_next   = stopped_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        total_next     = total_reg;
        status_next    = status_reg;

        if (q_pop)
        begin
            if (q_data.term)
            begin
                out_valid_next = 1'b1;
                total_next     = '0;
                if (q_data.rmode && at_start_reg)
                begin
                    status_next = ST_EMPTY;
                end
                else if (phase_reg != PH_NORMAL)
                begin
                    status_next = ST_UNTERM;
                end
                else
                begin
                    total_next = final_ext[OUT_TOTAL_BITS-1:0];
                    if (final_total == '0)
                    begin
                        status_next = ST_ZERO;
                    end
                    else if (final_total > 0)
                    begin
                        status_next = ST_OK;
                    end
                    else
                    begin
                        status_next = ST_NEGATIVE;
                    end
                end
                phase_next     = PH_NORMAL;
                after_sep_next = 1'b0;
                at_start_next  = 1'b1;
                running_next   = '0;
                start_next     = '0;
                acc_next       = '0;
                stopped_next   = 1'b0;
            end
            else
            begin
                at_start_next = 1'b0;
                unique case (phase_reg)
                    PH_FIRST:
                    begin
                        if (q_data.dash)
                        begin
                            start_next   = acc_reg;
                            acc_next     = '0;
                            stopped_next = 1'b0;
                            phase_next   = PH_LAST;
                        end
                        else
                        begin
                            acc_next     = acc_digit;
                            stopped_next = stop_digit;
                        end
                    end
                    PH_LAST:
                    begin
                        if (q_data.close)
                        begin
                            running_next = sat_add(SW'(running_reg), SW'(delta));
                            phase_next   = PH_NORMAL;
                        end
                        else
                        begin
                            acc_next     = acc_digit;
                            stopped_next = stop_digit;
                        end
                    end
                    default:
                    begin
                        if (q_data.delim)
                        begin
                            if (!after_sep_reg)
                            begin
                                running_next = sat_add(SW'(running_reg), ONE);
                            end
                            after_sep_next = 1'b1;
                        end
                        else
                        begin
                            after_sep_next = 1'b0;
                            if (q_data.open)
                            begin
                                phase_next   = PH_FIRST;
                                acc_next     = '0;
                                stopped_next = 1'b0;
                            end
                        end
                    end
                endcase
            end
        end
    end

    // State and registered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_NORMAL;
            after_sep_reg <= 1'b0;
            at_start_reg  <= 1'b1;
            running_reg   <= '0;
            start_reg     <= '0;
            acc_reg       <= '0;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
            status_reg    <= ST_OK;
        end
        else
        begin
            phase_reg     <= phase_next;
            after_sep_reg <= after_sep_next;
            at_start_reg  <= at_start_next;
            running_reg   <= running_next;
            start_reg     <= start_next;
            acc_reg       <= acc_next;
            stopped_reg   <= stopped_next;
            out_valid_reg <= out_valid_next;
            total_reg     <= total_next;
            status_reg    <= status_next;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.entry_total = total_reg;
    assign out_ch.status_code = status_reg;

endmodule

/* hdl/nlrc_checker.sv */
// Port-level checker of the node-list range counter, bound to the top level.
// Depends on nlrc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nlrc_checker
    import nlrc_pkg::*;
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic signed [OUT_TOTAL_BITS-1:0] entry_total,
    input logic        [STATUS_BITS-1:0]    status_code
);

    logic                                  stalled;
    logic                                  rejected;
    logic                                  zero_seen;
    logic [OUT_TOTAL_BITS+STATUS_BITS-1:0] result;

    // Conditions seen on the result channel.
    assign stalled   = out_valid && !out_ready;
    assign rejected  = out_valid && (status_code == ST_EMPTY || status_code == ST_UNTERM);
    assign zero_seen = out_valid && (status_code == ST_ZERO);
    assign result    = {entry_total, status_code};

    // A waiting result holds until it is taken.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, stalled, out_valid && $stable(result), "stalled result changed")

    // Rejected strings report a zero count.
    `ASSERT_SAME(a_reject_zero, clk, rst_n, rejected, entry_total == '0, "rejected string count")

    // A zero status goes with a zero count.
    `ASSERT_SAME(a_zero_status, clk, rst_n, zero_seen, entry_total == '0, "zero status count")

    // Status codes beyond the defined set never appear.
    `ASSERT_SAME(a_status_range, clk, rst_n, out_valid, status_code <= ST_UNTERM, "undefined status")

endmodule

bind node_list_range_counter nlrc_checker u_nlrc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .entry_total (out_ch.entry_total),
    .status_code (out_ch.status_code)
);

/* dv/tb_node_list_range_counter.sv */
// Testbench of node_list_range_counter: drives node-list strings byte by byte and
// checks every result against a scan predictor kept in this file, or typed rows against their own result.
// Depends on nlrc_pkg, the stream interfaces in nlrc_if.sv and the block itself.
`timescale 1ns / 1ps

module tb_node_list_range_counter;
    import nlrc_pkg::*;

    localparam int     CLK_PERIOD = 12;
    localparam int     CYCLE_LIMIT = 600000;
    localparam int     SETTLE_CYCLES = 6;
    localparam int     REPS_WIDE = 4;
    localparam longint CNT_MAX = (longint'(1) << (COUNT_BITS_DEF - 1)) - 1;
    localparam longint CNT_MIN = -CNT_MAX - 1;
    localparam longint VAL_MAX = (longint'(1) << RANGE_VALUE_BITS_DEF) - 1;

    typedef enum logic [1:0] {PH_NORMAL, PH_FIRST, PH_LAST} scan_e;

    typedef struct packed {
        logic signed [OUT_TOTAL_BITS-1:0] total;
        logic        [STATUS_BITS-1:0]    status;
    } tally_t;

    // A directed string row; typed rows carry their result, the rest use the predictor.
    typedef struct {
        logic                             mode;
        logic [BYTE_BITS-1:0]             sep;
        string                            text;
        int                               reps;
        logic                             typed;
        logic signed [OUT_TOTAL_BITS-1:0] total;
        logic        [STATUS_BITS-1:0]    status;
    } vector_t;

    typedef struct {
        logic   typed;
        tally_t want;
    } row_check_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    nlrc_in_if  in_ch ();
    nlrc_out_if out_ch ();

    node_list_range_counter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Predictor copy of the configuration and of the scan state.
    logic                 ranges_on;
    logic [BYTE_BITS-1:0] delim_char;
    scan_e                ph;
    logic                 sep_seen;
    logic                 fresh;
    longint               tally;
    longint               lo_val;
    longint               acc;
    logic                 stopped;

    tally_t               owed[$];
    row_check_t           row_checks[$];
    logic [BYTE_BITS-1:0] line_q[$];

    int fail_count;
    int cycles;
    int idle_pct;
    int stall_pct;

    vector_t vectors[] = '{
        '{1'b1, CH_COMMA, "",             1, 1'b1, 0,           ST_EMPTY},
        '{1'b1, CH_COMMA, "a,b,,c",       1, 1'b1, 3,           ST_OK},
        '{1'b1, CH_COMMA, "n[1-4],x",     1, 1'b0, 0,           ST_OK},
        '{1'b1, CH_COMMA, "[5-4]",        1, 1'b1, 0,           ST_ZERO},
        '{1'b1, CH_COMMA, "[1048575-0]",  1, 1'b1, -1048574,    ST_NEGATIVE},
        '{1'b1, CH_COMMA, "[99999999-0]", 1, 1'b0, 0,           ST_OK},
        '{1'b1, CH_COMMA, "[-5-3] x",     1, 1'b0, 0,           ST_OK},
        '{1'b1, CH_COMMA, "[1-",          1, 1'b1, 0,           ST_UNTERM},
        '{1'b1, CH_COMMA, "[12",          1, 1'b1, 0,           ST_UNTERM},
        '{1'b1, CH_COMMA, "a,,,",         1, 1'b0, 0,           ST_OK},
        '{1'b1, CH_COMMA, ",",            1, 1'b0, 0,           ST_OK},
        '{1'b1, CH_COMMA, "\001\177\200\377", 1, 1'b0, 0,       ST_OK},
        '{1'b1, CH_COMMA, "[0-9999999]",  REPS_WIDE, 1'b0, 0,   ST_OK},
        '{1'b1, CH_COMMA, "[9999999-0]",  REPS_WIDE, 1'b0, 0,   ST_OK},
        '{1'b0, 8'h3B,    "",             1, 1'b1, 1,           ST_OK},
        '{1'b0, 8'h3B,    "a;;b;[1-9],c;", 1, 1'b0, 0,          ST_OK},
        '{1'b0, 8'hFF,    "x\377\377y",   1, 1'b0, 0,           ST_OK},
        '{1'b0, 8'h00,    "a,b",          1, 1'b1, 1,           ST_OK},
        '{1'b0, CH_COMMA, "[3-1],z",      1, 1'b0, 0,           ST_OK}
    };

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // Run-length guard.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver side: ready follows the current stall rate.
    always @(posedge clk)
    begin
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    function automatic longint clamp_add(input longint a, input longint d);
        if (d > 0 && a > CNT_MAX - d)
            return CNT_MAX;
        if (d < 0 && a < CNT_MIN - d)
            return CNT_MIN;
        return a + d;
    endfunction

    function automatic void clear_scan();
        ph       = PH_NORMAL;
        sep_seen = 1'b0;
        fresh    = 1'b1;
        tally    = 0;
        lo_val   = 0;
        acc      = 0;
        stopped  = 1'b0;
    endfunction

    // Decimal value accumulation: stops at the first non-digit and saturates.
    function automatic void take_digit(input logic [BYTE_BITS-1:0] b);
        longint grown;
        if (stopped)
            return;
        if (b < CH_ZERO || b > CH_NINE)
        begin
            stopped = 1'b1;
            return;
        end
        grown = acc * 10 + longint'(b - CH_ZERO);
        acc = (grown > VAL_MAX) ? VAL_MAX : grown;
    endfunction

    // Advances the scan by one accepted byte; a terminator queues the expected result.
    function automatic void scan_byte(input logic [BYTE_BITS-1:0] b);
        tally_t               res;
        longint               sum;
        row_check_t           row;
        logic [BYTE_BITS-1:0] delim;
        if (b == CH_TERM)
        begin
            sum = 0;
            if (ranges_on && fresh)
                res.status = ST_EMPTY;
            else if (ph != PH_NORMAL)
                res.status = ST_UNTERM;
            else
            begin
                sum = clamp_add(tally, 1);
                if (sum == 0)
                    res.status = ST_ZERO;
                else if (sum > 0)
                    res.status = ST_OK;
                else
                    res.status = ST_NEGATIVE;
            end
            res.total = sum[OUT_TOTAL_BITS-1:0];
            // Directed rows may carry a result typed in by hand instead.
            if (row_checks.size() > 0)
            begin
                row = row_checks.pop_front();
                if (row.typed)
                    res = row.want;
            end
            owed.push_back(res);
            clear_scan();
            return;
        end

        fresh = 1'b0;
        if (ph == PH_FIRST)
        begin
            if (b == CH_DASH)
            begin
                lo_val  = acc;
                acc     = 0;
                stopped = 1'b0;
                ph      = PH_LAST;
            end
            else
                take_digit(b);
            return;
        end
        if (ph == PH_LAST)
        begin
            if (b == CH_CLOSE)
            begin
                tally = clamp_add(tally, acc - lo_val);
                ph    = PH_NORMAL;
            end
            else
                take_digit(b);
            return;
        end

        delim = ranges_on ? CH_COMMA : delim_char;
        if (b == delim)
        begin
            if (!sep_seen)
                tally = clamp_add(tally, 1);
            sep_seen = 1'b1;
        end
        else
        begin
            sep_seen = 1'b0;
            if (ranges_on && b == CH_OPEN)
            begin
                ph      = PH_FIRST;
                acc     = 0;
                stopped = 1'b0;
            end
        end
    endfunction

    // Transfer monitor: predicts on input transfers and checks output transfers.
    always @(posedge clk)
    begin
        tally_t want;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                scan_byte(in_ch.text_byte);
            if (out_ch.valid && out_ch.ready)
            begin
                if (owed.size() == 0)
                begin
                    $display("%0t: unexpected result total %0d status %0d", $time,
                             out_ch.entry_total, out_ch.status_code);
                    fail_count++;
                end
                else
                begin
                    want = owed.pop_front();
                    if (out_ch.entry_total !== want.total)
                    begin
                        $display("%0t: entry_total expected %0d actual %0d", $time,
                                 want.total, out_ch.entry_total);
                        fail_count++;
                    end
                    if (out_ch.status_code !== want.status)
                    begin
                        $display("%0t: status_code expected %0d actual %0d", $time,
                                 want.status, out_ch.status_code);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Offers one byte, with random idle cycles first, and returns once it is taken.
    task automatic push_byte(input logic [BYTE_BITS-1:0] b);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.text_byte <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // Stops sending and waits until every result has come back and the block is quiet.
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (owed.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes both registers on back-to-back cycles; the block must be idle.
    task automatic set_config(input logic mode, input logic [BYTE_BITS-1:0] sep);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SEPARATOR;
        cfg_data  <= sep;
        @(posedge clk);
        cfg_index <= CFG_RANGE_MODE;
        cfg_data  <= CFG_DATA_BITS'(mode);
        @(posedge clk);
        cfg_we     <= 1'b0;
        delim_char = sep;
        ranges_on  = mode;
    endtask

    // Appends a decimal value, mostly small, sometimes past the value limit.
    task automatic add_number();
        int    v;
        string s;
        if ($urandom_range(0, 9) == 0)
            line_q.push_back(($urandom_range(0, 1) == 0) ? CH_DASH : 8'h20);
        v = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 9999999) : $urandom_range(0, 40);
        s = $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++)
            line_q.push_back(s[i]);
    endtask

    // Builds one node list: mostly well-formed names and ranges, some noise.
    task automatic compose_line();
        logic [BYTE_BITS-1:0] dch;
        int                   entries;
        line_q.delete();
        dch = ranges_on ? CH_COMMA : delim_char;
        // A zero separator cannot appear inside a string.
        if (dch == CH_TERM)
            dch = CH_COMMA;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(0, 12))
                line_q.push_back(BYTE_BITS'($urandom_range(1, 255)));
            return;
        end
        if ($urandom_range(0, 5) == 0)
            line_q.push_back(dch);
        entries = $urandom_range(1, 5);
        for (int k = 0; k < entries; k++)
        begin
            if (k > 0)
                repeat (($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1)
                    line_q.push_back(dch);
            repeat ($urandom_range(1, 3))
                line_q.push_back(BYTE_BITS'(8'h61 + $urandom_range(0, 25)));
            if ($urandom_range(0, 2) == 0)
            begin
                // Bracketed range, now and then missing its dash or its closing bracket.
                line_q.push_back(CH_OPEN);
                add_number();
                if ($urandom_range(0, 7) != 0)
                    line_q.push_back(CH_DASH);
                add_number();
                if ($urandom_range(0, 7) != 0)
                    line_q.push_back(CH_CLOSE);
            end
            else if ($urandom_range(0, 1) == 0)
                add_number();
        end
        if ($urandom_range(0, 5) == 0)
            line_q.push_back(dch);
        foreach (line_q[i])
            if ($urandom_range(0, 15) == 0)
                line_q[i] = BYTE_BITS'($urandom_range(1, 255));
    endtask

    // Stimulus.
    initial
    begin
        row_check_t row;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_SEPARATOR;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.text_byte = '0;
        out_ch.ready    = 1'b0;
        fail_count      = 0;
        cycles          = 0;
        idle_pct        = 0;
        stall_pct       = 0;
        ranges_on       = RANGE_MODE_RESET;
        delim_char      = SEPARATOR_RESET;
        clear_scan();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows, starting under the reset configuration.
        foreach (vectors[r])
        begin
            if (vectors[r].mode != ranges_on || vectors[r].sep != delim_char)
            begin
                settle();
                set_config(vectors[r].mode, vectors[r].sep);
            end
            row.typed       = vectors[r].typed;
            row.want.total  = vectors[r].total;
            row.want.status = vectors[r].status;
            row_checks.push_back(row);
            repeat (vectors[r].reps)
                for (int i = 0; i < vectors[r].text.len(); i++)
                    push_byte(vectors[r].text[i]);
            push_byte(CH_TERM);
        end

        // Random node lists under each idling pattern and several settings.
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 77; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 77; end
                default: begin idle_pct = 26; stall_pct = 26; end
            endcase
            for (int c = 0; c < 3; c++)
            begin
                settle();
                case (c)
                    0: set_config(1'b1, BYTE_BITS'($urandom_range(0, 255)));
                    1: set_config(1'b0, BYTE_BITS'($urandom_range(33, 126)));
                    default: set_config(1'b0, (p % 2 == 0) ? 8'hFF : 8'h00);
                endcase
                repeat (2)
                begin
                    compose_line();
                    foreach (line_q[i])
                        push_byte(line_q[i]);
                    push_byte(CH_TERM);
                end
            end
        end

        settle();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
